// ===== rtl/wcht_pkg.sv =====
package wcht_pkg;

  localparam int TABLE_SIZE = 59;
  localparam int LEN_W    = 7;
  localparam int HASH_W   = 64;
  localparam int CNT_W    = 32;
  localparam int SLOT_W   = 6;
  localparam int DKEYS_W  = 6;
  localparam logic [HASH_W-1:0] HASH_START = 64'd5381;
  localparam int HASH_SHIFT = 5;
  localparam logic [CNT_W-1:0] CNT_SAT = '1;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] key_char;
    logic       key_last;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [CNT_W-1:0]   occurrences;
    logic [SLOT_W-1:0]  slot;
    logic               inserted;
    logic               table_full;
    logic [DKEYS_W-1:0] distinct_keys;
    logic [CNT_W-1:0]   collision_total;
  } rsp_t;

  // job header handed from front to back
  typedef struct packed {
    logic              cmd;
    logic [LEN_W-1:0]  len;
    logic [HASH_W-1:0] hash;
  } job_hdr_t;

endpackage

// ===== rtl/word_count_hash_table.sv =====
// Word-frequency hash table of 59 slots. Send a key one character per item
// with start; key_last marks its final character, and cmd on that item picks
// add or lookup. Characters are taken one per cycle while busy is low. Once
// the back end takes a completed key, it reduces the 64-bit hash modulo the
// table size, 16 bits per step of reciprocal estimate and corrective subtract,
// then walks the slots; each probe is one store read and compare. A two-entry
// queue lets the next keys stream in meanwhile; busy rises only when it is full.
// Each key gives one result on rsp, valid for the single cycle that done is
// high; the receiver cannot stall it. The table is empty after reset with no
// clearing pass.
module word_count_hash_table #(
  parameter int MAX_KEY_CHARS = 19
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  wcht_pkg::req_t req,
  output logic           done,
  output wcht_pkg::rsp_t rsp
);
  import wcht_pkg::*;

  localparam int KEY_BITS = 8 * MAX_KEY_CHARS;
  localparam int QW       = $bits(job_hdr_t) + KEY_BITS;

  logic                push;
  job_hdr_t            push_hdr;
  logic [KEY_BITS-1:0] push_key;
  logic                pop;
  logic [QW-1:0]       q_out;
  logic                q_empty;
  logic                q_full;
  job_hdr_t            job_hdr;
  logic [KEY_BITS-1:0] job_key;

  assign busy = q_full;
  assign {job_hdr, job_key} = q_out;

  wcht_front #(.MAX_KEY_CHARS(MAX_KEY_CHARS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (start && !busy),
    .req      (req),
    .push     (push),
    .push_hdr (push_hdr),
    .push_key (push_key)
  );

  wcht_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_hdr, push_key}),
    .pop       (pop),
    .pop_data  (q_out),
    .empty     (q_empty),
    .full      (q_full)
  );

  wcht_back #(.MAX_KEY_CHARS(MAX_KEY_CHARS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_ready (!q_empty),
    .job_hdr   (job_hdr),
    .job_key   (job_key),
    .job_pop   (pop),
    .done      (done),
    .rsp       (rsp)
  );
endmodule

// ===== rtl/wcht_ram.sv =====
module wcht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/wcht_queue.sv =====
// Two-entry job queue between front and back
module wcht_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full
);
  logic [WIDTH-1:0] mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign empty    = (count == 2'd0);
  assign full     = (count == 2'd2);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ===== rtl/wcht_front.sv =====
// Collects key characters and the running hash, emits one job per key
module wcht_front #(
  parameter int MAX_KEY_CHARS = 19
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  wcht_pkg::req_t            req,
  output logic                      push,
  output wcht_pkg::job_hdr_t        push_hdr,
  output logic [8*MAX_KEY_CHARS-1:0] push_key
);
  import wcht_pkg::*;

  localparam int KEY_BITS = 8 * MAX_KEY_CHARS;

  logic [LEN_W-1:0]    len;
  logic [LEN_W-1:0]    len_next;
  logic [HASH_W-1:0]   hash;
  logic [HASH_W-1:0]   hash_next;
  logic [KEY_BITS-1:0] key;
  logic [KEY_BITS-1:0] key_next;

  // append the character while there is room; a fresh key starts cleared
  always_comb begin
    len_next  = len;
    hash_next = hash;
    key_next  = (len == '0) ? '0 : key;
    if (len < LEN_W'(MAX_KEY_CHARS)) begin
      for (int j = 0; j < MAX_KEY_CHARS; j++) begin
        if (len == LEN_W'(j)) key_next[8*j +: 8] = req.key_char;
      end
      len_next  = len + LEN_W'(1);
      hash_next = (hash << HASH_SHIFT) + hash + {{(HASH_W-8){1'b0}}, req.key_char};
    end
  end

  assign push          = accept && req.key_last;
  assign push_hdr.cmd  = req.cmd;
  assign push_hdr.len  = len_next;
  assign push_hdr.hash = hash_next;
  assign push_key      = key_next;

  always_ff @(posedge clk) begin
    if (accept) key <= key_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len  <= '0;
      hash <= HASH_START;
    end else if (accept) begin
      if (req.key_last) begin
        len  <= '0;
        hash <= HASH_START;
      end else begin
        len  <= len_next;
        hash <= hash_next;
      end
    end
  end
endmodule

// ===== rtl/wcht_back.sv =====
// Reduces the hash to a home slot, probes the table, updates it, reports
module wcht_back #(
  parameter int MAX_KEY_CHARS = 19
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_ready,
  input  wcht_pkg::job_hdr_t         job_hdr,
  input  logic [8*MAX_KEY_CHARS-1:0] job_key,
  output logic                       job_pop,
  output logic                       done,
  output wcht_pkg::rsp_t             rsp
);
  import wcht_pkg::*;

  localparam int KEY_BITS = 8 * MAX_KEY_CHARS;
  localparam int IW       = $clog2(TABLE_SIZE);
  localparam int SC_W     = $clog2(TABLE_SIZE + 1);
  localparam int EW       = KEY_BITS + LEN_W + CNT_W;
  localparam int CH_W     = 16;
  localparam int XW       = IW + CH_W;
  localparam logic [XW-1:0] RECIP = XW'((64'd1 << XW) / 64'(TABLE_SIZE));
  localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_SIZE - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_PROBE = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [1:0] HIT_NONE  = 2'd0;
  localparam logic [1:0] HIT_EMPTY = 2'd1;
  localparam logic [1:0] HIT_MATCH = 2'd2;

  logic [2:0]          state;
  job_hdr_t            hdr;
  logic [KEY_BITS-1:0] key;
  logic [IW-1:0]       rem;
  logic [1:0]          chunk_idx;
  logic                div_phase;
  logic [XW-1:0]       div_x;
  logic [2*XW-1:0]     div_prod;
  logic [IW-1:0]       s;
  logic [IW-1:0]       probes;
  logic                home_occ;
  logic [1:0]          kind;
  logic [CNT_W-1:0]    hit_count;
  logic [TABLE_SIZE-1:0] valid;
  logic [SC_W-1:0]     stored;
  logic [CNT_W-1:0]    collisions;

  logic [XW-1:0]       x_cur;
  logic [2*XW-1:0]     prod_next;
  logic [XW-1:0]       quo;
  logic [XW-1:0]       diff;
  logic [IW-1:0]       rem_next;
  logic                ram_we;
  logic [EW-1:0]       ram_wdata;
  logic [EW-1:0]       ram_rdata;
  logic [KEY_BITS-1:0] rd_key;
  logic [LEN_W-1:0]    rd_len;
  logic [CNT_W-1:0]    rd_count;
  logic [CNT_W-1:0]    new_count;
  logic                is_add;

  // hash mod TABLE_SIZE, 16 bits per step, most significant first:
  // reciprocal estimate of the quotient, then one corrective subtract
  always_comb begin
    x_cur     = {rem, hdr.hash[chunk_idx*CH_W +: CH_W]};
    prod_next = (2*XW)'(x_cur) * (2*XW)'(RECIP);
    quo       = div_prod[2*XW-1:XW];
    diff      = div_x - quo * XW'(TABLE_SIZE);
    rem_next  = (diff >= XW'(TABLE_SIZE)) ? IW'(diff - XW'(TABLE_SIZE)) : IW'(diff);
  end

  assign {rd_key, rd_len, rd_count} = ram_rdata;
  assign is_add    = (hdr.cmd == CMD_ADD);
  assign new_count = (kind == HIT_MATCH)
                   ? ((hit_count == CNT_SAT) ? hit_count : hit_count + CNT_W'(1))
                   : CNT_W'(1);
  assign ram_we    = (state == ST_DONE) && is_add && (kind != HIT_NONE);
  assign ram_wdata = {key, hdr.len, new_count};
  assign job_pop   = (state == ST_IDLE) && job_ready;

  wcht_ram #(.WIDTH(EW), .DEPTH(TABLE_SIZE)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s),
    .wdata (ram_wdata),
    .raddr (s),
    .rdata (ram_rdata)
  );

  // job payload registers
  always_ff @(posedge clk) begin
    if (job_pop) begin
      hdr <= job_hdr;
      key <= job_key;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      valid      <= '0;
      stored     <= '0;
      collisions <= '0;
      done       <= 1'b0;
      rem        <= '0;
      chunk_idx  <= '0;
      div_phase  <= 1'b0;
      div_x      <= '0;
      div_prod   <= '0;
      s          <= '0;
      probes     <= '0;
      home_occ   <= 1'b0;
      kind       <= HIT_NONE;
      hit_count  <= '0;
      rsp        <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (job_ready) begin
            rem       <= '0;
            chunk_idx <= 2'd3;
            div_phase <= 1'b0;
            state     <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (!div_phase) begin
            div_x     <= x_cur;
            div_prod  <= prod_next;
            div_phase <= 1'b1;
          end else begin
            rem       <= rem_next;
            div_phase <= 1'b0;
            chunk_idx <= chunk_idx - 2'd1;
            if (chunk_idx == 2'd0) begin
              s      <= rem_next;
              probes <= '0;
              state  <= ST_PROBE;
            end
          end
        end
        ST_PROBE: begin
          if (probes == '0) home_occ <= valid[s];
          if (!valid[s]) begin
            kind  <= HIT_EMPTY;
            state <= ST_DONE;
          end else begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (rd_len == hdr.len && rd_key == key) begin
            kind      <= HIT_MATCH;
            hit_count <= rd_count;
            state     <= ST_DONE;
          end else if (probes == LAST_SLOT) begin
            kind  <= HIT_NONE;
            state <= ST_DONE;
          end else begin
            s      <= (s == LAST_SLOT) ? '0 : s + IW'(1);
            probes <= probes + IW'(1);
            state  <= ST_PROBE;
          end
        end
        ST_DONE: begin
          logic [SC_W-1:0]  stored_new;
          logic [CNT_W-1:0] coll_new;
          stored_new = stored;
          coll_new   = collisions;
          if (is_add && home_occ && collisions != CNT_SAT) coll_new = collisions + CNT_W'(1);
          if (is_add && kind == HIT_EMPTY) begin
            valid[s]   <= 1'b1;
            stored_new = stored + SC_W'(1);
          end
          stored     <= stored_new;
          collisions <= coll_new;
          done       <= 1'b1;
          rsp.found           <= (kind == HIT_MATCH);
          rsp.occurrences     <= (kind == HIT_MATCH) ? (is_add ? new_count : hit_count)
                               : ((kind == HIT_EMPTY && is_add) ? CNT_W'(1) : '0);
          rsp.slot            <= (kind == HIT_NONE || (kind == HIT_EMPTY && !is_add))
                               ? '0 : SLOT_W'(s);
          rsp.inserted        <= is_add && (kind == HIT_EMPTY);
          rsp.table_full      <= (kind == HIT_NONE);
          rsp.distinct_keys   <= DKEYS_W'(stored_new);
          rsp.collision_total <= coll_new;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_done_from_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_DONE) else $error("result without finish step");
  a_not_both: assert property (@(posedge clk) disable iff (rst)
    done |-> !(rsp.found && rsp.inserted)) else $error("found and inserted together");
  a_stored_bound: assert property (@(posedge clk) disable iff (rst)
    stored <= SC_W'(TABLE_SIZE)) else $error("entry count above table size");
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && is_add && kind == HIT_EMPTY) |=> stored == $past(stored) + SC_W'(1))
    else $error("insert did not raise entry count");
endmodule
